// ===== sv/a64div_pkg.sv =====
`default_nettype none

package a64div_pkg;

  localparam int unsigned OP_W   = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CNT_W  = 6;

  // Operation select carried on the input tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_UNSIGNED = 2'd0,
    MODE_SIGNED   = 2'd1,
    MODE_SWAPPED  = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_DIVIDE,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic reduce;
    logic step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fits;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/a64div_datapath.sv =====
`default_nettype none

module a64div_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire a64div_pkg::cmd_t               cmd,
  output a64div_pkg::status_t                 status,
  input  wire logic [a64div_pkg::MODE_W-1:0]  mode,
  input  wire logic [a64div_pkg::OP_W-1:0]    dividend,
  input  wire logic [a64div_pkg::OP_W-1:0]    divisor,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [a64div_pkg::OP_W-1:0]         m_tdata
);

  localparam int unsigned W = a64div_pkg::OP_W;
  localparam int unsigned H = a64div_pkg::HALF_W;

  // num shifts out dividend bits at the top and takes quotient bits at the bottom
  logic [W-1:0] num;
  logic [W-1:0] den;
  logic [H-1:0] rest;
  logic         flip;

  logic         is_signed;
  logic [W-1:0] op_a;
  logic [W-1:0] op_b;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [H:0]   trial;
  logic [H:0]   diff;
  logic         take;

  // Pick operand roles for the mode
  always_comb begin
    is_signed = 1'b0;
    op_a      = dividend;
    op_b      = divisor;
    unique case (a64div_pkg::mode_t'(mode))
      a64div_pkg::MODE_SIGNED: begin
        is_signed = 1'b1;
      end
      a64div_pkg::MODE_SWAPPED: begin
        is_signed = 1'b1;
        op_a      = divisor;
        op_b      = dividend;
      end
      default: begin
        is_signed = 1'b0;
      end
    endcase
    mag_a = (is_signed && op_a[W-1]) ? (~op_a + W'(1)) : op_a;
    mag_b = (is_signed && op_b[W-1]) ? (~op_b + W'(1)) : op_b;
  end

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rest, num[W-1]};
    diff  = trial - {1'b0, den[H-1:0]};
    take  = (trial >= {1'b0, den[H-1:0]});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num  <= mag_a;
      den  <= mag_b;
      rest <= '0;
      flip <= is_signed && (op_a[W-1] ^ op_b[W-1]);
    end else if (cmd.reduce) begin
      num <= num >> 1;
      den <= den >> 1;
    end else if (cmd.step) begin
      num  <= {num[W-2:0], take};
      rest <= take ? diff[H-1:0] : trial[H-1:0];
    end
  end

  // Output register: apply the sign fix on the way in, hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= flip ? (~num + W'(1)) : num;
    end
  end

  assign status.fits     = (den[W-1:H] == '0);
  assign status.out_free = !m_tvalid || m_tready;

  // Division steps only run on a reduced divisor
  a_step_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (den[W-1:H] == '0))
    else $error("divide step with unreduced divisor");

  // Partial remainder stays below a nonzero divisor
  a_rest_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && (den[H-1:0] != '0)) |-> (rest < den[H-1:0]))
    else $error("partial remainder out of range");

  // A finished result is presented on the next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("result not presented after finish");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && m_tvalid) |-> m_tready)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== sv/a64div_ctrl.sv =====
`default_nettype none

module a64div_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire a64div_pkg::status_t  status,
  output a64div_pkg::cmd_t          cmd
);

  a64div_pkg::state_t                state;
  a64div_pkg::state_t                state_next;
  logic [a64div_pkg::CNT_W-1:0]      count;
  logic [a64div_pkg::CNT_W-1:0]      count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= a64div_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Sequence: load, shift divisor into 32 bits, 64 quotient steps, sign fix
  always_comb begin
    state_next = state;
    count_next = count;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      a64div_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = a64div_pkg::S_REDUCE;
        end
      end
      a64div_pkg::S_REDUCE: begin
        if (status.fits) begin
          count_next = '1;
          state_next = a64div_pkg::S_DIVIDE;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      a64div_pkg::S_DIVIDE: begin
        cmd.step   = 1'b1;
        count_next = count - 1'b1;
        if (count == '0) begin
          state_next = a64div_pkg::S_FINISH;
        end
      end
      a64div_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = a64div_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = a64div_pkg::S_IDLE;
      end
    endcase
  end

  // At most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.reduce, cmd.step, cmd.finish}))
    else $error("conflicting datapath commands");

  // Last quotient step leads to the finish state
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (state == a64div_pkg::S_DIVIDE && count == '0) |=> (state == a64div_pkg::S_FINISH))
    else $error("divide loop did not end after 64 steps");

  // Input is only taken while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == a64div_pkg::S_IDLE))
    else $error("input ready outside idle");

endmodule

`default_nettype wire

// ===== sv/approx_64bit_divider_core.sv =====
`default_nettype none

// 64-bit divider with unsigned, signed and signed-swapped modes. Signed modes
// divide magnitudes and negate the quotient when exactly one operand is
// negative. A divisor magnitude wider than 32 bits is shifted right together
// with the dividend, one place per cycle, until it fits, so the quotient is
// approximate in that case; the reduced dividend is then divided exactly by
// one restoring shift-subtract step per cycle. A zero divisor gives all ones
// before the sign fix. Mode 3 acts as unsigned. From input transfer to result,
// an item passes through the load, the reduction shifts, 64 quotient steps and
// the sign fix. One item is in flight at a time; the next is taken while the
// last result waits for its output transfer.
module approx_64bit_divider_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // [63:0] dividend, [127:64] divisor
  input  wire logic [1:0]   s_tuser,   // [1:0] mode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata    // [63:0] quotient
);

  a64div_pkg::cmd_t    cmd;
  a64div_pkg::status_t status;

  a64div_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  a64div_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .mode     (s_tuser),
    .dividend (s_tdata[63:0]),
    .divisor  (s_tdata[127:64]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // [63:0] dividend, [127:64] divisor
  logic [1:0]   s_tuser = '0;   // [1:0] mode
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;        // [63:0] quotient

  logic [63:0] pending_quotients[$];
  int          error_count = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  approx_64bit_divider_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected quotient: magnitudes in signed modes, shift both down until the
  // divisor fits in 32 bits, floor divide, then fix the sign.
  function automatic logic [63:0] predict_quotient(input a64div_pkg::mode_t mode,
                                                   input logic [63:0] dividend,
                                                   input logic [63:0] divisor);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quot;
    logic        negate;
    num    = dividend;
    den    = divisor;
    negate = 1'b0;
    if (mode == a64div_pkg::MODE_SWAPPED) begin
      num = divisor;
      den = dividend;
    end
    if (mode == a64div_pkg::MODE_SIGNED || mode == a64div_pkg::MODE_SWAPPED) begin
      if (num[63]) begin
        num    = 64'd0 - num;
        negate = ~negate;
      end
      if (den[63]) begin
        den    = 64'd0 - den;
        negate = ~negate;
      end
    end
    while (den > 64'hFFFF_FFFF) begin
      num = num >> 1;
      den = den >> 1;
    end
    if (den == 64'd0)
      quot = '1;
    else
      quot = num / den;
    if (negate)
      quot = 64'd0 - quot;
    return quot;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Random operand: full width, a random narrower width, its negation, or a
  // boundary value
  function automatic logic [63:0] random_operand();
    logic [63:0] raw;
    int          width;
    raw   = {$urandom, $urandom};
    width = $urandom_range(64, 1);
    case ($urandom_range(7))
      0, 1, 2: random_operand = raw;
      3, 4:    random_operand = raw >> (64 - width);
      5:       random_operand = 64'd0 - (raw >> (64 - width));
      default: begin
        case ($urandom_range(6))
          0:       random_operand = 64'd0;
          1:       random_operand = 64'd1;
          2:       random_operand = '1;
          3:       random_operand = 64'h8000_0000_0000_0000;
          4:       random_operand = 64'h0000_0000_FFFF_FFFF;
          5:       random_operand = 64'h0000_0001_0000_0000;
          default: random_operand = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Drive one division request and hold it until the transfer
  task automatic send_division(input a64div_pkg::mode_t mode,
                               input logic [63:0] dividend,
                               input logic [63:0] divisor);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {divisor, dividend};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic run_random_divisions(input int count);
    repeat (count)
      send_division(a64div_pkg::mode_t'(2'($urandom_range(3))),
                    random_operand(), random_operand());
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_division(a64div_pkg::MODE_UNSIGNED, 64'd100, 64'd7);
    send_division(a64div_pkg::MODE_UNSIGNED, 64'd0, 64'd0);
    send_division(a64div_pkg::MODE_UNSIGNED, '1, 64'd1);
    send_division(a64div_pkg::MODE_UNSIGNED, '1, '1);
    send_division(a64div_pkg::MODE_UNSIGNED, 64'd5, 64'h0000_0000_FFFF_FFFF);
    send_division(a64div_pkg::MODE_UNSIGNED, 64'h8000_0000_0000_0000,
                  64'h0000_0001_0000_0000);
    send_division(a64div_pkg::MODE_UNSIGNED, 64'h1234_5678_9ABC_DEF0,
                  64'h0000_0001_FFFF_FFFF);
    send_division(a64div_pkg::MODE_UNSIGNED, 64'd0, '1);
    send_division(a64div_pkg::MODE_SIGNED, 64'd0 - 64'd100, 64'd7);
    send_division(a64div_pkg::MODE_SIGNED, 64'd100, 64'd0 - 64'd7);
    send_division(a64div_pkg::MODE_SIGNED, 64'd0 - 64'd100, 64'd0 - 64'd7);
    send_division(a64div_pkg::MODE_SIGNED, 64'h8000_0000_0000_0000, 64'd1);
    send_division(a64div_pkg::MODE_SIGNED, 64'h8000_0000_0000_0000,
                  64'h8000_0000_0000_0000);
    send_division(a64div_pkg::MODE_SIGNED, 64'd0 - 64'd5, 64'd0);
    send_division(a64div_pkg::MODE_SIGNED, 64'd5, 64'd0);
    send_division(a64div_pkg::MODE_SIGNED, '1, 64'd1);
    send_division(a64div_pkg::MODE_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, '1);
    send_division(a64div_pkg::MODE_SWAPPED, 64'd7, 64'd100);
    send_division(a64div_pkg::MODE_SWAPPED, 64'd0, 64'd0 - 64'd3);
    send_division(a64div_pkg::MODE_SWAPPED, 64'd0 - 64'd7, 64'h8000_0000_0000_0000);
    send_division(a64div_pkg::MODE_SWAPPED, 64'h0000_0002_0000_0001,
                  64'h7FFF_FFFF_FFFF_FFFF);
    send_division(a64div_pkg::MODE_SPARE, '1, 64'd3);
    send_division(a64div_pkg::MODE_SPARE, 64'd0, 64'd0);
    send_division(a64div_pkg::MODE_SPARE, 64'hFFFF_0000_FFFF_0000,
                  64'h0000_0123_4567_89AB);
  endtask

  task automatic test_back_to_back();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    run_random_divisions(450);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 47;
    recv_stall_pct  = 0;
    run_random_divisions(450);
  endtask

  task automatic test_receiver_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 47;
    run_random_divisions(450);
  endtask

  task automatic test_both_sides_idle();
    sender_idle_pct = 20;
    recv_stall_pct  = 20;
    run_random_divisions(450);
  endtask

  // Stall the result side at random
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Queue a prediction on each input transfer; check each output transfer
  always @(posedge clk) begin : result_check
    logic [63:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        pending_quotients.push_back(
          predict_quotient(a64div_pkg::mode_t'(s_tuser), s_tdata[63:0],
                           s_tdata[127:64]));
      if (m_tvalid && m_tready) begin
        if (pending_quotients.size() == 0) begin
          report_mismatch($sformatf("unexpected quotient %h", m_tdata));
        end else begin
          want = pending_quotients.pop_front();
          if (m_tdata !== want)
            report_mismatch($sformatf("quotient %h, want %h", m_tdata, want));
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_backpressure();
    test_both_sides_idle();
    s_tvalid <= 1'b0;
    // Drain outstanding quotients, then allow one worst-case item of slack
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (error_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
